>>> rtl/pidtr_pkg.sv
// ----------------------------------------------------------------------------
// pidtr_pkg
// Types, register map and control store for the PID temperature regulator.
// ----------------------------------------------------------------------------
package pidtr_pkg;

    localparam int TEMP_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int BAND_W  = 8;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int INTEG_W = 32;
    localparam int OPB_W   = 34;
    localparam int PROD_W  = GAIN_W + 1 + OPB_W;
    localparam int ACC_W   = 52;
    localparam int FRAC_W  = 24;
    localparam int PC_W    = 3;

    localparam logic [2:0] REG_SETPOINT   = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [2:0] REG_STEP_TIME  = 3'd4;
    localparam logic [2:0] REG_INV_STEP   = 3'd5;
    localparam logic [2:0] REG_DEADBAND   = 3'd6;

    localparam logic [PC_W-1:0] PC_FINISH = 3'd7;

    typedef struct packed {
        logic signed [TEMP_W-1:0] setpoint;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic [GAIN_W-1:0]        step_time;
        logic [GAIN_W-1:0]        inv_step_time;
        logic [BAND_W-1:0]        deriv_deadband;
    } cfg_t;

    typedef enum logic [2:0] {
        GAIN_STEP,
        GAIN_INV,
        GAIN_PROP,
        GAIN_INTEG,
        GAIN_DERIV
    } gain_sel_t;

    typedef enum logic [1:0] {
        OPB_ERR,
        OPB_DIFF,
        OPB_INTEG,
        OPB_PROD
    } opb_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        gain_sel_t       gain;
        opb_sel_t        opb;
        logic            mul_en;
        logic            ld_err;
        logic            ld_diff;
        logic            ld_integ;
        acc_op_t         acc_op;
        logic            jmp_clear;
        logic            jmp_band;
        logic [PC_W-1:0] target;
        logic            finish;
    } uop_t;

    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u = '{gain: GAIN_STEP, opb: OPB_ERR, mul_en: 1'b0, ld_err: 1'b0, ld_diff: 1'b0,
              ld_integ: 1'b0, acc_op: ACC_HOLD, jmp_clear: 1'b0, jmp_band: 1'b0,
              target: PC_FINISH, finish: 1'b0};
        case (pc)
            3'd0: begin
                u.ld_err    = 1'b1;
                u.jmp_clear = 1'b1;
            end
            3'd1: begin
                u.gain    = GAIN_STEP;
                u.opb     = OPB_ERR;
                u.mul_en  = 1'b1;
                u.ld_diff = 1'b1;
            end
            3'd2: begin
                u.ld_integ = 1'b1;
                u.gain     = GAIN_PROP;
                u.opb      = OPB_ERR;
                u.mul_en   = 1'b1;
            end
            3'd3: begin
                u.acc_op = ACC_LOAD;
                u.gain   = GAIN_INTEG;
                u.opb    = OPB_INTEG;
                u.mul_en = 1'b1;
            end
            3'd4: begin
                u.acc_op   = ACC_ADD;
                u.gain     = GAIN_INV;
                u.opb      = OPB_DIFF;
                u.mul_en   = 1'b1;
                u.jmp_band = 1'b1;
            end
            3'd5: begin
                u.gain   = GAIN_DERIV;
                u.opb    = OPB_PROD;
                u.mul_en = 1'b1;
            end
            3'd6: begin
                u.acc_op = ACC_ADD;
            end
            3'd7: begin
                u.finish = 1'b1;
            end
            default: begin
                u.finish = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

>>> rtl/pidtr_datapath.sv
// ----------------------------------------------------------------------------
// pidtr_datapath
// Shared multiplier, accumulator and loop state, steered by one control word
// per cycle.
// ----------------------------------------------------------------------------
module pidtr_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  logic                                  kind_in,
    input  logic signed [pidtr_pkg::TEMP_W-1:0]   meas_in,
    input  pidtr_pkg::cfg_t                       cfg,
    input  pidtr_pkg::uop_t                       uop,
    output logic                                  kind,
    output logic                                  band_hit,
    output logic signed [pidtr_pkg::TEMP_W-1:0]   drive,
    output logic                                  saturated
);

    localparam int ERR_W   = pidtr_pkg::ERR_W;
    localparam int DIFF_W  = pidtr_pkg::DIFF_W;
    localparam int INTEG_W = pidtr_pkg::INTEG_W;
    localparam int OPB_W   = pidtr_pkg::OPB_W;
    localparam int PROD_W  = pidtr_pkg::PROD_W;
    localparam int ACC_W   = pidtr_pkg::ACC_W;
    localparam int FRAC_W  = pidtr_pkg::FRAC_W;
    localparam int GAIN_W  = pidtr_pkg::GAIN_W;
    localparam int Q_W     = ACC_W - FRAC_W;

    logic                       kind_reg;
    logic signed [15:0]         meas_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [ERR_W-1:0]    prev_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       sat_reg;

    logic [GAIN_W-1:0]          gain;
    logic signed [OPB_W-1:0]    opb;
    logic signed [ERR_W-1:0]    err_now;
    logic signed [INTEG_W:0]    integ_sum;
    logic                       integ_clamp;
    logic [DIFF_W-1:0]          diff_mag;
    logic signed [ACC_W-1:0]    acc_adj;
    logic signed [Q_W-1:0]      quot;
    logic                       drive_clamp;

    always_comb begin
        case (uop.gain)
            pidtr_pkg::GAIN_STEP:  gain = cfg.step_time;
            pidtr_pkg::GAIN_INV:   gain = cfg.inv_step_time;
            pidtr_pkg::GAIN_PROP:  gain = cfg.prop_gain;
            pidtr_pkg::GAIN_INTEG: gain = cfg.integ_gain;
            pidtr_pkg::GAIN_DERIV: gain = cfg.deriv_gain;
            default:               gain = '0;
        endcase
        case (uop.opb)
            pidtr_pkg::OPB_ERR:   opb = OPB_W'(err_reg);
            pidtr_pkg::OPB_DIFF:  opb = OPB_W'(diff_reg);
            pidtr_pkg::OPB_INTEG: opb = OPB_W'(integ_reg);
            pidtr_pkg::OPB_PROD:  opb = prod_reg[OPB_W-1:0];
            default:              opb = '0;
        endcase
    end

    assign err_now = ERR_W'(cfg.setpoint) - ERR_W'(meas_reg);

    // floor of the Q.24 increment down to Q.16
    assign integ_sum = (INTEG_W+1)'(integ_reg)
                     + (INTEG_W+1)'($signed(prod_reg[ERR_W+GAIN_W-1:8]));

    always_comb begin
        integ_clamp = 1'b0;
        integ_next  = integ_sum[INTEG_W-1:0];
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_clamp = 1'b1;
            integ_next  = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                             : {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    assign diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : diff_reg;
    assign band_hit = diff_mag <= DIFF_W'(cfg.deriv_deadband);

    // truncate toward zero
    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'({FRAC_W{1'b1}}) : ACC_W'(0));
    assign quot    = acc_adj[ACC_W-1:FRAC_W];

    always_comb begin
        drive_clamp = 1'b0;
        drive       = quot[15:0];
        if (quot > Q_W'(32767)) begin
            drive_clamp = 1'b1;
            drive       = 16'sh7fff;
        end else if (quot < -Q_W'(32768)) begin
            drive_clamp = 1'b1;
            drive       = 16'sh8000;
        end
        if (kind_reg) begin
            drive       = '0;
            drive_clamp = 1'b0;
        end
    end

    assign saturated = kind_reg ? 1'b0 : (sat_reg | drive_clamp);
    assign kind      = kind_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_in;
            meas_reg <= meas_in;
        end
        if (uop.ld_err) begin
            err_reg <= err_now;
        end
        if (uop.ld_diff) begin
            diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        end
        if (uop.mul_en) begin
            prod_reg <= $signed({1'b0, gain}) * opb;
        end
        case (uop.acc_op)
            pidtr_pkg::ACC_LOAD: acc_reg <= {prod_reg[ACC_W-9:0], 8'b0};
            pidtr_pkg::ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:             acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (uop.ld_err) begin
                sat_reg <= 1'b0;
                if (kind_reg) begin
                    integ_reg <= '0;
                    prev_reg  <= '0;
                end
            end
            if (uop.ld_integ) begin
                integ_reg <= integ_next;
                prev_reg  <= err_reg;
                sat_reg   <= integ_clamp;
            end
        end
    end

endmodule

>>> rtl/pid_temperature_regulator.sv
// ----------------------------------------------------------------------------
// pid_temperature_regulator
// Discrete PID regulator for temperature samples, Q7.8 in, whole units out.
// ----------------------------------------------------------------------------
// One item is taken at a time. A temperature sample runs through an eight-step
// control program over one shared 17x34 multiplier, skipping the derivative
// steps when the error change lies inside the derivative deadband; a clear
// request jumps from the first step to the last. The result waits in an output
// register; the next item is accepted once the program is back at its first
// step, in the cycle after the result is registered. The last step holds while
// the output register is full and not being taken. Registers are to be written
// by the user over the APB port only while idle; the block does not enforce it.
module pid_temperature_regulator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] measured_temp
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] drive
    output logic [0:0]  m_tuser,   // [0] saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PC_W = pidtr_pkg::PC_W;

    pidtr_pkg::cfg_t    cfg_reg;
    pidtr_pkg::uop_t    uop;
    logic               busy_reg, busy_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_data_reg;
    logic               m_sat_reg;
    logic               accept, wr_en, stall, retire;
    logic               kind, band_hit, sat;
    logic signed [15:0] drive;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{setpoint: 16'sd6400, prop_gain: 16'd8960, integ_gain: 16'd307,
                         deriv_gain: 16'd115, step_time: 16'd19726,
                         inv_step_time: 16'd850, deriv_deadband: 8'd0};
        end else if (wr_en) begin
            case (reg_idx)
                pidtr_pkg::REG_SETPOINT:   cfg_reg.setpoint       <= pwdata[15:0];
                pidtr_pkg::REG_PROP_GAIN:  cfg_reg.prop_gain      <= pwdata[15:0];
                pidtr_pkg::REG_INTEG_GAIN: cfg_reg.integ_gain     <= pwdata[15:0];
                pidtr_pkg::REG_DERIV_GAIN: cfg_reg.deriv_gain     <= pwdata[15:0];
                pidtr_pkg::REG_STEP_TIME:  cfg_reg.step_time      <= pwdata[15:0];
                pidtr_pkg::REG_INV_STEP:   cfg_reg.inv_step_time  <= pwdata[15:0];
                pidtr_pkg::REG_DEADBAND:   cfg_reg.deriv_deadband <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pidtr_pkg::REG_SETPOINT:   prdata = {16'b0, cfg_reg.setpoint};
            pidtr_pkg::REG_PROP_GAIN:  prdata = {16'b0, cfg_reg.prop_gain};
            pidtr_pkg::REG_INTEG_GAIN: prdata = {16'b0, cfg_reg.integ_gain};
            pidtr_pkg::REG_DERIV_GAIN: prdata = {16'b0, cfg_reg.deriv_gain};
            pidtr_pkg::REG_STEP_TIME:  prdata = {16'b0, cfg_reg.step_time};
            pidtr_pkg::REG_INV_STEP:   prdata = {16'b0, cfg_reg.inv_step_time};
            pidtr_pkg::REG_DEADBAND:   prdata = {24'b0, cfg_reg.deriv_deadband};
            default:                   prdata = '0;
        endcase
    end

    assign uop      = busy_reg ? pidtr_pkg::ucode(pc_reg) : '0;
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid & s_tready;
    assign stall    = m_valid_reg & !m_tready;
    assign retire   = busy_reg & uop.finish & !stall;

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            pc_next   = '0;
        end else if (busy_reg) begin
            if (uop.finish) begin
                if (!stall) begin
                    busy_next    = 1'b0;
                    pc_next      = '0;
                    m_valid_next = 1'b1;
                end
            end else if ((uop.jmp_clear && kind) || (uop.jmp_band && band_hit)) begin
                pc_next = uop.target;
            end else begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            m_data_reg <= drive;
            m_sat_reg  <= sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

    pidtr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .kind_in   (s_tuser[0]),
        .meas_in   (s_tdata),
        .cfg       (cfg_reg),
        .uop       (uop),
        .kind      (kind),
        .band_hit  (band_hit),
        .drive     (drive),
        .saturated (sat)
    );

endmodule

>>> test/pidtr_checker.sv
// ----------------------------------------------------------------------------
// pidtr_checker
// Watches the sample, drive and APB ports of the PID temperature regulator.
// It keeps its own copy of the register file, the integral and the last error,
// works out the drive and the clamp flag for every input beat, and compares
// each output beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package pidtr_tb_pkg;

    typedef enum logic {
        KIND_SAMPLE,
        KIND_CLEAR
    } item_kind_t;

    localparam logic [2:0] REG_UNUSED = 3'd7;

endpackage

module pidtr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] measured_temp
    input  logic [0:0]  s_tuser,   // [0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] drive
    input  logic [0:0]  m_tuser,   // [0] saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint INTEG_MAX = 2147483647;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint DRIVE_MAX = 32767;
    localparam longint DRIVE_MIN = -32768;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } drive_beat_t;

    pidtr_pkg::cfg_t cfg;
    longint          integral_acc;
    longint          last_error;
    drive_beat_t     pending_drive[$];

    task automatic report_mismatch(input string what);
        fail_count = fail_count + 1;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic drive_beat_t regulate(input logic signed [15:0] temp);
        longint      err;
        longint      integ;
        longint      diff;
        longint      mag;
        longint      deriv;
        longint      sum;
        longint      cmd;
        logic        clamped;
        drive_beat_t res;
        clamped = 1'b0;
        err     = longint'($signed(cfg.setpoint)) - longint'(temp);

        integ = integral_acc + ((err * longint'(cfg.step_time)) >>> 8);
        if (integ > INTEG_MAX) begin
            integ   = INTEG_MAX;
            clamped = 1'b1;
        end
        if (integ < INTEG_MIN) begin
            integ   = INTEG_MIN;
            clamped = 1'b1;
        end
        integral_acc = integ;

        diff  = err - last_error;
        mag   = (diff < 0) ? -diff : diff;
        deriv = (mag <= longint'(cfg.deriv_deadband)) ? 0 :
                diff * longint'(cfg.inv_step_time);

        sum = longint'(cfg.prop_gain) * err * 256 + longint'(cfg.integ_gain) * integ
            + longint'(cfg.deriv_gain) * deriv;
        // truncate toward zero to whole units
        cmd = sum / 64'sd16777216;
        if (cmd > DRIVE_MAX) begin
            cmd     = DRIVE_MAX;
            clamped = 1'b1;
        end
        if (cmd < DRIVE_MIN) begin
            cmd     = DRIVE_MIN;
            clamped = 1'b1;
        end
        last_error = err;

        res.drive     = cmd[15:0];
        res.saturated = clamped;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        drive_beat_t want;
        if (!aresetn) begin
            cfg = '{setpoint: 16'sd6400, prop_gain: 16'd8960, integ_gain: 16'd307,
                    deriv_gain: 16'd115, step_time: 16'd19726, inv_step_time: 16'd850,
                    deriv_deadband: 8'd0};
            integral_acc = 0;
            last_error   = 0;
            pending_drive.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    pidtr_pkg::REG_SETPOINT:   cfg.setpoint       = pwdata[15:0];
                    pidtr_pkg::REG_PROP_GAIN:  cfg.prop_gain      = pwdata[15:0];
                    pidtr_pkg::REG_INTEG_GAIN: cfg.integ_gain     = pwdata[15:0];
                    pidtr_pkg::REG_DERIV_GAIN: cfg.deriv_gain     = pwdata[15:0];
                    pidtr_pkg::REG_STEP_TIME:  cfg.step_time      = pwdata[15:0];
                    pidtr_pkg::REG_INV_STEP:   cfg.inv_step_time  = pwdata[15:0];
                    pidtr_pkg::REG_DEADBAND:   cfg.deriv_deadband = pwdata[7:0];
                    default: ;
                endcase
            end
            // compare before queueing, so a beat cannot match its own prediction
            if (m_tvalid && m_tready) begin
                if (pending_drive.size() == 0) begin
                    report_mismatch($sformatf("drive beat %0d with nothing outstanding",
                                              $signed(m_tdata)));
                end else begin
                    want = pending_drive.pop_front();
                    if (m_tdata !== want.drive)
                        report_mismatch($sformatf("drive %0d, predicted %0d",
                                                  $signed(m_tdata), want.drive));
                    if (m_tuser[0] !== want.saturated)
                        report_mismatch($sformatf("saturated %b, predicted %b",
                                                  m_tuser[0], want.saturated));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == pidtr_tb_pkg::KIND_CLEAR) begin
                    integral_acc = 0;
                    last_error   = 0;
                    pending_drive.push_back('{drive: 16'sd0, saturated: 1'b0});
                end else begin
                    pending_drive.push_back(regulate(s_tdata));
                end
            end
        end
        pending <= pending_drive.size();
    end

endmodule

>>> test/pid_temperature_regulator_tb.sv
// ----------------------------------------------------------------------------
// pid_temperature_regulator_tb
// Stimulus and verdict for the PID temperature regulator.
// A short directed run under reset settings, then phases that drive the
// integral into both clamps, zero every gain and period, and sweep random
// settings, with random gaps on both streams and one long output hold-off.
// Prediction and comparison live in pidtr_checker.
// ----------------------------------------------------------------------------
module pid_temperature_regulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] measured_temp
    logic [0:0]  s_tuser  = '0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] drive
    logic [0:0]  m_tuser;          // [0] saturated
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;

    pid_temperature_regulator u_dut (.*);

    pidtr_checker u_checker (.*);

    always #1 aclk = ~aclk;

    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] sp, input logic [31:0] kp,
                                 input logic [31:0] ki, input logic [31:0] kd,
                                 input logic [31:0] st, input logic [31:0] inv,
                                 input logic [31:0] band);
        apb_write(pidtr_pkg::REG_SETPOINT, sp);
        apb_write(pidtr_pkg::REG_PROP_GAIN, kp);
        apb_write(pidtr_pkg::REG_INTEG_GAIN, ki);
        apb_write(pidtr_pkg::REG_DERIV_GAIN, kd);
        apb_write(pidtr_pkg::REG_STEP_TIME, st);
        apb_write(pidtr_pkg::REG_INV_STEP, inv);
        apb_write(pidtr_pkg::REG_DEADBAND, band);
    endtask

    task automatic send_item(input pidtr_tb_pkg::item_kind_t kind, input logic [15:0] temp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= temp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // anchored: scatter around base; otherwise random walk with occasional jumps
    task automatic run_phase(input int count, input int base, input int spread,
                             input int clear_odds, input int jump_odds, input bit anchored);
        int t;
        t = base;
        repeat (count) begin
            if (anchored)
                t = base + int'($urandom_range(0, 2 * spread)) - spread;
            else if (jump_odds != 0 && $urandom_range(1, jump_odds) == 1)
                t = int'($signed(16'($urandom)));
            else
                t = t + int'($urandom_range(0, 2 * spread)) - spread;
            if (t > 32767)
                t = 32767;
            if (t < -32768)
                t = -32768;
            if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1)
                send_item(pidtr_tb_pkg::KIND_CLEAR, 16'($urandom));
            else
                send_item(pidtr_tb_pkg::KIND_SAMPLE, 16'(t));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : drive_sink
        int stall;
        int beats;
        beats = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (beats == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            beats++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [15:0] probes [10];
        probes = '{16'd6400, 16'd6400, 16'd6401, 16'd6144, 16'h8000,
                   16'h7fff, 16'h0000, 16'h5555, 16'haaaa, 16'hffff};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i])
            send_item(pidtr_tb_pkg::KIND_SAMPLE, probes[i]);
        send_item(pidtr_tb_pkg::KIND_CLEAR, 16'h7fff);
        send_item(pidtr_tb_pkg::KIND_SAMPLE, 16'd6400);
        send_item(pidtr_tb_pkg::KIND_SAMPLE, 16'd6400);
        send_item(pidtr_tb_pkg::KIND_CLEAR, 16'h0000);
        settle();

        // full scale: drive the integral into its upper clamp, no idling
        no_idle = 1'b1;
        load_settings(32'h7fff, 32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'hff);
        apb_write(pidtr_tb_pkg::REG_UNUSED, $urandom);
        send_item(pidtr_tb_pkg::KIND_CLEAR, 16'($urandom));
        run_phase(140, -32768, 400, 0, 0, 1'b1);
        settle();

        // lowest setpoint: drive the integral into its lower clamp
        no_idle = 1'b0;
        load_settings(32'h8000, $urandom, 32'hffff, $urandom, 32'hffff, $urandom,
                      $urandom_range(0, 255));
        send_item(pidtr_tb_pkg::KIND_CLEAR, 16'($urandom));
        run_phase(140, 32767, 400, 0, 0, 1'b1);
        settle();

        // zero gains and periods
        load_settings(32'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        run_phase(25, 0, 300, 8, 4, 1'b0);
        settle();

        for (int p = 0; p < 3; p++) begin
            no_idle = (p == 1);
            load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            run_phase(40, int'($signed(16'($urandom))), 300, 25, 10, 1'b0);
            settle();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
